>>> hw/rtl/hafp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafp_pkg
// shared widths, codes and the broadcast command bundle of the hole allocator
// ----------------------------------------------------------------------------
package hafp_pkg;

  localparam int DEF_MAX_HOLES = 32;

  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 5;
  localparam int SIZE_W   = 16;
  localparam int POL_W    = 2;
  localparam int HIU_W    = 6;
  localparam int CHOSEN_W = 5;
  localparam int TOTAL_W  = 21;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;

  localparam logic [TOTAL_W-1:0] SUM_MAX = {TOTAL_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd2;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic CFG_FIT_POLICY   = 1'b0;
  localparam logic CFG_HOLES_IN_USE = 1'b1;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              load;
    logic              clear;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] want;
    logic [POL_W-1:0]  policy;
    logic [HIU_W-1:0]  holes_in_use;
  } cmd_t;

endpackage

>>> hw/rtl/hole_allocator_fit_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hole_allocator_fit_policy
// hole table with used marks, placing requests by first, best or worst fit
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+--------------------------------
//  s       | in  | s_tvalid_i / s_tready_o | tdata: slot, size; tuser: mode
//  m       | out | m_tvalid_o / m_tready_i | tdata: granted, hole, left, total
//  cfg     | in  | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
//  load and clear words act when accepted; a request runs through the accept,
//  a scan while the candidate walks the registered cell chain, and a commit
//  that marks the hole used and fills the output register
//  reset clears used marks, the leftover total, config and control state;
//  hole sizes hold garbage until loaded
//  a request finishing while the output register is still full waits in the
//  commit state until m_tready_i frees it
// ----------------------------------------------------------------------------
module hole_allocator_fit_policy #(
  parameter int MAX_HOLES = hafp_pkg::DEF_MAX_HOLES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slot[4:0], item_size[20:5], zero pad
  input  logic [hafp_pkg::S_TDATA_W-1:0] s_tdata_i,
  // mode[1:0]
  input  logic [hafp_pkg::S_TUSER_W-1:0] s_tuser_i,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // granted[0], chosen_hole[5:1], leftover[21:6], total_leftover[42:22], pad
  output logic [hafp_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_addr_i,
  input  logic [hafp_pkg::HIU_W-1:0]     cfg_wdata_i
);
  import hafp_pkg::*;

  localparam int IDX_W = $clog2(MAX_HOLES);
  localparam int CNT_W = $clog2(MAX_HOLES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_HOLES - 1);
  localparam int OUT_PAD_W = M_TDATA_W - 1 - CHOSEN_W - SIZE_W - TOTAL_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [POL_W-1:0]   policy_q;
  logic [HIU_W-1:0]   hiu_q;
  logic [SIZE_W-1:0]  want_q;
  logic [TOTAL_W-1:0] sum_q;
  logic               out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;

  logic [MODE_W-1:0]  in_mode;
  logic [SLOT_W-1:0]  in_slot;
  logic [SIZE_W-1:0]  in_size;
  logic               in_acc;
  logic               commit;
  cmd_t               cmd;

  // candidate chain, entry 0 is the empty head, entry MAX_HOLES the tail
  logic               ch_found [MAX_HOLES+1];
  logic [IDX_W-1:0]   ch_idx   [MAX_HOLES+1];
  logic [SIZE_W-1:0]  ch_size  [MAX_HOLES+1];

  logic [SIZE_W-1:0]  left;
  logic [TOTAL_W:0]   sum_wide;
  logic [TOTAL_W-1:0] sum_next;
  logic [CHOSEN_W-1:0] chosen;

  assign in_mode = s_tuser_i[MODE_W-1:0];
  assign in_slot = s_tdata_i[SLOT_W-1:0];
  assign in_size = s_tdata_i[SLOT_W +: SIZE_W];

  assign s_tready_o = (state_q == ST_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  // commit when the output register is free or being emptied now
  assign commit     = (state_q == ST_COMMIT) && (!out_valid_q || m_tready_i);

  // config registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      hiu_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FIT_POLICY:   policy_q <= cfg_wdata_i[POL_W-1:0];
        CFG_HOLES_IN_USE: hiu_q    <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  always_comb begin
    cmd.load         = in_acc && (in_mode == MODE_LOAD);
    cmd.clear        = in_acc && (in_mode == MODE_CLEAR);
    cmd.slot         = in_slot;
    cmd.size         = in_size;
    cmd.want         = want_q;
    cmd.policy       = policy_q;
    cmd.holes_in_use = hiu_q;
  end

  // request size stays put for the whole scan
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_mode == MODE_REQUEST)) begin
      want_q <= in_size;
    end
  end

  assign ch_found[0] = 1'b0;
  assign ch_idx[0]   = '0;
  assign ch_size[0]  = '0;

  for (genvar k = 0; k < MAX_HOLES; k++) begin : g_cell
    hafp_cell #(
      .INDEX (k),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .mark_i       (commit && ch_found[MAX_HOLES]),
      .mark_idx_i   (ch_idx[MAX_HOLES]),
      .cand_found_i (ch_found[k]),
      .cand_idx_i   (ch_idx[k]),
      .cand_size_i  (ch_size[k]),
      .cand_found_o (ch_found[k+1]),
      .cand_idx_o   (ch_idx[k+1]),
      .cand_size_o  (ch_size[k+1])
    );
  end

  // leftover and saturating running total
  assign left     = ch_found[MAX_HOLES] ? (ch_size[MAX_HOLES] - want_q) : '0;
  assign sum_wide = {1'b0, sum_q} + (TOTAL_W+1)'(left);
  assign sum_next = sum_wide[TOTAL_W] ? SUM_MAX : sum_wide[TOTAL_W-1:0];
  assign chosen   = ch_found[MAX_HOLES] ? CHOSEN_W'(ch_idx[MAX_HOLES]) :
                                          {CHOSEN_W{1'b0}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd.clear) begin
      sum_q <= '0;
    end else if (commit) begin
      sum_q <= sum_next;
    end
  end

  // sequencer: idle, walk the chain once, commit
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc && (in_mode == MODE_REQUEST)) state_d = ST_SCAN;
      ST_SCAN:   if (cnt_q == LAST_CNT) state_d = ST_COMMIT;
      ST_COMMIT: if (commit) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, sum_next, left, chosen, ch_found[MAX_HOLES]};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

>>> hw/rtl/hafp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafp_cell
// one hole entry: size, used mark and one stage of the candidate chain
// ----------------------------------------------------------------------------
module hafp_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hafp_pkg::cmd_t           cmd_i,
  input  logic                     mark_i,
  input  logic [IDX_W-1:0]         mark_idx_i,
  input  logic                     cand_found_i,
  input  logic [IDX_W-1:0]         cand_idx_i,
  input  logic [hafp_pkg::SIZE_W-1:0] cand_size_i,
  output logic                     cand_found_o,
  output logic [IDX_W-1:0]         cand_idx_o,
  output logic [hafp_pkg::SIZE_W-1:0] cand_size_o
);
  import hafp_pkg::*;

  logic [SIZE_W-1:0] size_q;
  logic              used_q;
  logic              found_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SIZE_W-1:0] csize_q;
  logic              active;
  logic              elig;
  logic              take;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(cmd_i.slot) == 32'(INDEX))) begin
      size_q <= cmd_i.size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (cmd_i.clear) begin
      used_q <= 1'b0;
    end else if (mark_i && (32'(mark_idx_i) == 32'(INDEX))) begin
      used_q <= 1'b1;
    end
  end

  assign active = 32'(cmd_i.holes_in_use) > 32'(INDEX);
  assign elig   = active && !used_q && (size_q >= cmd_i.want);

  // ties keep the earlier (lower index) candidate
  always_comb begin
    take = 1'b0;
    if (elig) begin
      if (!cand_found_i) begin
        take = 1'b1;
      end else begin
        case (cmd_i.policy)
          POL_BEST:  take = size_q < cand_size_i;
          POL_WORST: take = size_q > cand_size_i;
          default:   take = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= take || cand_found_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q   <= IDX_W'(INDEX);
      csize_q <= size_q;
    end else begin
      idx_q   <= cand_idx_i;
      csize_q <= cand_size_i;
    end
  end

  assign cand_found_o = found_q;
  assign cand_idx_o   = idx_q;
  assign cand_size_o  = csize_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hole allocator with first, best and worst fit
// ----------------------------------------------------------------------------
// A table model in a small class mirrors the hole sizes, used marks and the
// leftover total. Every accepted input word goes into the model. Each request
// queues its expected placement, and each output word is checked field by
// field against the oldest queued placement. The table is fully loaded before
// any request, so no request ever reads an unwritten hole size. A directed
// section covers the policies, tie breaks and corner cases. Random phases
// then sweep the policy and table size registers under several idle and
// stall mixes, with one long output stall and one full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import hafp_pkg::*;

  localparam int MAX_HOLES      = DEF_MAX_HOLES;
  localparam int RX_HOLD_CYCLES = 300;  // long output stall, fills the block
  localparam int SETTLE_CYCLES  = 40;   // a bit more than one request latency
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_WORDS    = 58;
  localparam int BURST_WORDS    = 10;

  // mode three is not decoded by the block and must be dropped
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  // one expected output word
  typedef struct packed {
    logic                granted;
    logic [CHOSEN_W-1:0] hole;
    logic [SIZE_W-1:0]   left;
    logic [TOTAL_W-1:0]  total;
  } placement_t;

  // mirror of the hole table plus the queue of placements still owed
  class hole_table_model;
    logic [SIZE_W-1:0]  hole_size [MAX_HOLES];
    bit                 hole_used [MAX_HOLES];
    logic [TOTAL_W-1:0] total;
    logic [POL_W-1:0]   policy;
    logic [HIU_W-1:0]   holes_in_use;
    placement_t         placements_due [$];
    int                 errors;

    function new();
      foreach (hole_size[k]) begin
        hole_size[k] = '0;
        hole_used[k] = 1'b0;
      end
      total        = '0;
      policy       = POL_FIRST;
      holes_in_use = '0;
      errors       = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("tb: mismatch: %s", what);
    endtask

    function void write_reg(logic addr, logic [HIU_W-1:0] data);
      if (addr == CFG_FIT_POLICY) policy = data[POL_W-1:0];
      else holes_in_use = data;
    endfunction

    // choose a hole under the current policy and commit it
    function placement_t place_request(logic [SIZE_W-1:0] want);
      int                 n;
      int                 pick;
      logic [SIZE_W-1:0]  pick_size;
      logic [TOTAL_W:0]   sum;
      placement_t         res;
      n = (holes_in_use > MAX_HOLES) ? MAX_HOLES : int'(holes_in_use);
      pick = -1;
      pick_size = '0;
      res = '0;
      for (int k = 0; k < n; k++) begin
        if (!hole_used[k] && hole_size[k] >= want) begin
          if (pick < 0) begin
            pick = k;
            pick_size = hole_size[k];
          end else if (policy == POL_BEST && hole_size[k] < pick_size) begin
            pick = k;
            pick_size = hole_size[k];
          end else if (policy == POL_WORST && hole_size[k] > pick_size) begin
            pick = k;
            pick_size = hole_size[k];
          end
        end
      end
      if (pick >= 0) begin
        hole_used[pick] = 1'b1;
        res.granted = 1'b1;
        res.hole    = pick[CHOSEN_W-1:0];
        res.left    = pick_size - want;
        sum = {1'b0, total} + (TOTAL_W+1)'(res.left);
        total = (sum > SUM_MAX) ? SUM_MAX : sum[TOTAL_W-1:0];
      end
      res.total = total;
      return res;
    endfunction

    function void note_word(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                            logic [SIZE_W-1:0] size);
      case (mode)
        MODE_LOAD: begin
          if (slot < MAX_HOLES) hole_size[slot] = size;
        end
        MODE_CLEAR: begin
          foreach (hole_used[k]) hole_used[k] = 1'b0;
          total = '0;
        end
        MODE_REQUEST: begin
          placements_due.push_back(place_request(size));
        end
        default: ;
      endcase
    endfunction

    task check_word(logic [M_TDATA_W-1:0] data);
      placement_t exp_p;
      placement_t got;
      got.granted = data[0];
      got.hole    = data[5:1];
      got.left    = data[21:6];
      got.total   = data[42:22];
      if (placements_due.size() == 0) begin
        report($sformatf("output word %h with no request pending", data));
        return;
      end
      exp_p = placements_due.pop_front();
      if (got.granted != exp_p.granted)
        report($sformatf("granted %0d, want %0d", got.granted, exp_p.granted));
      if (got.hole != exp_p.hole)
        report($sformatf("chosen_hole %0d, want %0d", got.hole, exp_p.hole));
      if (got.left != exp_p.left)
        report($sformatf("leftover %0d, want %0d", got.left, exp_p.left));
      if (got.total != exp_p.total)
        report($sformatf("total_leftover %0d, want %0d", got.total, exp_p.total));
    endtask
  endclass

  // dut side signals; the inputs are known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata_i   = '0;
  logic [S_TUSER_W-1:0] s_tuser_i   = '0;
  logic                 s_tvalid_i  = 1'b0;
  logic                 s_tready_o;
  logic [M_TDATA_W-1:0] m_tdata_o;
  logic                 m_tvalid_o;
  logic                 m_tready_i  = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic                 cfg_addr_i  = 1'b0;
  logic [HIU_W-1:0]     cfg_wdata_i = '0;

  // knobs shared between the main sequence and the output driver
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_seq     = 0;

  hole_table_model tbl;

  logic [HIU_W-1:0] phase_pol [NUM_PHASES];
  logic [HIU_W-1:0] phase_hiu [NUM_PHASES];

  always #1 clk_i = ~clk_i;

  hole_allocator_fit_policy #(
    .MAX_HOLES(MAX_HOLES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tdata_o  (m_tdata_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // output monitor: values read here are the ones present at the edge
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) tbl.check_word(m_tdata_o);
  end

  // output ready driver, with a long hold-off on request from the main flow
  initial begin : rx_driver
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        m_tready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_tready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // random input gap; valid only drops when a gap is really taken
  task automatic idle_gap();
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // offer one word and wait for the handshake; valid stays high afterwards
  task automatic push_word(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                           logic [SIZE_W-1:0] size);
    s_tdata_i  <= {{(S_TDATA_W - SLOT_W - SIZE_W){1'b0}}, size, slot};
    s_tuser_i  <= mode;
    s_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    tbl.note_word(mode, slot, size);
  endtask

  // wait for every owed result, then let any load or clear finish
  task automatic settle();
    while (tbl.placements_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both registers while the block is idle
  task automatic program_regs(logic [HIU_W-1:0] pol_word, logic [HIU_W-1:0] hiu_word);
    s_tvalid_i <= 1'b0;
    settle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_FIT_POLICY;
    cfg_wdata_i <= pol_word;
    @(posedge clk_i);
    tbl.write_reg(CFG_FIT_POLICY, pol_word);
    cfg_addr_i  <= CFG_HOLES_IN_USE;
    cfg_wdata_i <= hiu_word;
    @(posedge clk_i);
    tbl.write_reg(CFG_HOLES_IN_USE, hiu_word);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly requests sized against the current table, some loads, clears and ignored-mode words
  task automatic random_word(bit req_only);
    int                r;
    int                k;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
    r    = $urandom_range(99);
    slot = SLOT_W'($urandom);
    size = SIZE_W'($urandom);
    if (req_only || r < 76) mode = MODE_REQUEST;
    else if (r < 90) mode = MODE_LOAD;
    else if (r < 96) mode = MODE_CLEAR;
    else mode = MODE_IGNORED;
    k = $urandom_range(MAX_HOLES - 1);
    r = $urandom_range(99);
    if (mode == MODE_REQUEST) begin
      // zero, exact fits, partial fits and mostly oversized random sizes
      if (r < 8) size = '0;
      else if (r < 25) size = tbl.hole_size[k];
      else if (r < 80) size = tbl.hole_size[k] >> $urandom_range(1, 6);
    end else if (mode == MODE_LOAD) begin
      // copies of other entries give size ties
      if (r < 20) size = tbl.hole_size[k];
      else if (r < 40) size = SIZE_W'($urandom_range(255));
    end
    push_word(mode, slot, size);
  endtask

  initial begin
    tbl = new();
    phase_pol = '{6'd0, 6'd1, 6'd2, 6'h3F, 6'd1, 6'd2, 6'd0, 6'h3E, 6'h3D, 6'd3};
    phase_hiu = '{6'd32, 6'd32, 6'd16, 6'd63, 6'd1, 6'd0, 6'd5, 6'd32, 6'd24, 6'd2};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load the whole table first so no request reads an unwritten size
    // slots 1 and 3 tie, slot 4 is the largest, slot 5 is empty
    push_word(MODE_LOAD, 5'd0, 16'd100);
    push_word(MODE_LOAD, 5'd1, 16'd50);
    push_word(MODE_LOAD, 5'd2, 16'd200);
    push_word(MODE_LOAD, 5'd3, 16'd50);
    push_word(MODE_LOAD, 5'd4, 16'hFFFF);
    push_word(MODE_LOAD, 5'd5, 16'd0);
    for (int k = 6; k < MAX_HOLES; k++) push_word(MODE_LOAD, k[SLOT_W-1:0], 16'(300 + 97 * k));

    // reset value of holes_in_use is zero, so nothing can be placed
    push_word(MODE_REQUEST, 5'd0, 16'd5);

    // first fit: zero size, full size twice, dropped mode, reload of used hole
    program_regs(HIU_W'(POL_FIRST), 6'd32);
    push_word(MODE_REQUEST, 5'd0, 16'd0);
    push_word(MODE_REQUEST, 5'd0, 16'hFFFF);
    push_word(MODE_REQUEST, 5'd31, 16'hFFFF);
    push_word(MODE_IGNORED, 5'd31, 16'hFFFF);
    push_word(MODE_REQUEST, 5'd0, 16'd100);
    push_word(MODE_LOAD, 5'd0, 16'd7);
    push_word(MODE_CLEAR, 5'd0, 16'd0);
    push_word(MODE_REQUEST, 5'd0, 16'd8);
    push_word(MODE_LOAD, 5'd1, 16'd9);
    push_word(MODE_REQUEST, 5'd0, 16'd9);

    // best fit with a size tie, then the empty hole
    program_regs(HIU_W'(POL_BEST), 6'd32);
    push_word(MODE_CLEAR, 5'd0, 16'd0);
    push_word(MODE_LOAD, 5'd1, 16'd50);
    push_word(MODE_REQUEST, 5'd0, 16'd50);
    push_word(MODE_REQUEST, 5'd0, 16'd50);
    push_word(MODE_REQUEST, 5'd0, 16'd0);

    // worst fit
    program_regs(HIU_W'(POL_WORST), 6'd32);
    push_word(MODE_REQUEST, 5'd0, 16'd1);
    push_word(MODE_REQUEST, 5'd0, 16'd1);

    // policy three acts as first fit, holes_in_use above the table is capped
    program_regs(6'h3F, 6'h3F);
    push_word(MODE_CLEAR, 5'd0, 16'd0);
    push_word(MODE_LOAD, 5'd31, 16'hFFFF);
    push_word(MODE_REQUEST, 5'd0, 16'hFFFF);
    push_word(MODE_REQUEST, 5'd0, 16'hFFFF);

    // a one-entry table runs out after one placement
    program_regs(HIU_W'(POL_FIRST), 6'd1);
    push_word(MODE_CLEAR, 5'd0, 16'd0);
    push_word(MODE_REQUEST, 5'd0, 16'd0);
    push_word(MODE_REQUEST, 5'd0, 16'd0);

    // random phases cycling through no idling, input gaps, output stalls, both
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_regs(phase_pol[p], phase_hiu[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
      endcase
      push_word(MODE_CLEAR, 5'd0, 16'd0);
      if (p == 2) begin
        // hold the output off while requests keep coming back to back,
        // then stop sending until every placement has come out
        hold_seq++;
        for (int i = 0; i < BURST_WORDS; i++) random_word(1'b1);
        s_tvalid_i <= 1'b0;
        while (tbl.placements_due.size() != 0) @(posedge clk_i);
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        idle_gap();
        random_word(1'b0);
      end
    end

    s_tvalid_i <= 1'b0;
    settle();
    if (tbl.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
